FILE: hdl/bpu_pkg.sv
package bpu_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Pixel format codes
    localparam logic [2:0] FMT_BGRX = 3'd0;
    localparam logic [2:0] FMT_BGR  = 3'd1;
    localparam logic [2:0] FMT_565  = 3'd2;
    localparam logic [2:0] FMT_555  = 3'd3;
    localparam logic [2:0] FMT_PAL  = 3'd4;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic [11:0] image_width;
        logic [11:0] image_height;
    } cfg_t;

    typedef enum logic {
        JOB_PIXEL,
        JOB_PAL_WRITE
    } job_kind_t;

    // One classified item handed from the front to the back.
    // Pixel: held = earlier bytes, byte_val = final byte.
    // Palette write: held = B,G,R, byte_val = entry index.
    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  fmt;
        logic [23:0] held;
        logic [7:0]  byte_val;
        logic [10:0] row;
        logic [10:0] col;
        logic        last;
    } job_t;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (fmt) inside
            FMT_BGRX: n = 3'd4;
            FMT_BGR:  n = 3'd3;
            FMT_565, FMT_555: n = 3'd2;
            FMT_PAL:  n = 3'd1;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    // Zero bytes that bring a row of wlo (mod 4) pixels to a 4-byte boundary
    function automatic logic [1:0] row_pad(input logic [1:0] wlo, input logic [2:0] bpp);
        logic [1:0] prod;
        prod = 2'(wlo * bpp);
        return 2'd0 - prod;
    endfunction

endpackage

FILE: hdl/bmp_pixel_unpacker.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tdata: data_byte; tuser: start_of_image
// m_        out  m_tvalid/m_tready    tdata: red, green, blue, row, col; tlast: last
// cfg_      in   cfg_we               cfg_addr selects format, width, height
//
// One byte is taken every cycle while the queue has room; a completed pixel passes
// through the queue, the registered palette read and the output register.
// Reset is synchronous on aresetn low and clears all counters; the format returns
// to 24-bit and width and height to one. The palette memory is not cleared and
// holds nothing useful until the stream loads it.
// A four-entry queue between the byte sequencer and the pixel back end absorbs
// output stalls; s_tready drops only when that queue is full.
module bmp_pixel_unpacker #(
    parameter int MAX_WIDTH       = 2048,
    parameter int MAX_HEIGHT      = 2048,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] start_of_image
    // pixel stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                   // [34:24] pixel_row, [45:35] pixel_col, [47:46] zero
    output logic        m_tlast    // last_pixel
);

    bpu_pkg::cfg_t cfg_reg;

    bpu_pkg::job_t front_job, back_job;
    logic          front_valid, front_ready;
    logic          back_valid, back_ready;

    logic [7:0]    red, green, blue;
    logic [10:0]   pixel_row, pixel_col;

    // Hold the registers; writes to an unused index drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format <= bpu_pkg::FMT_BGR;
            cfg_reg.image_width  <= 12'd1;
            cfg_reg.image_height <= 12'd1;
        end else if (cfg_we) begin
            case (cfg_addr)
                bpu_pkg::CFG_FORMAT: cfg_reg.pixel_format <= cfg_wdata[2:0];
                bpu_pkg::CFG_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                bpu_pkg::CFG_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: palette load, pixel assembly, padding skip and row/column count
    bpu_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_sof    (s_tuser[0]),
        .in_ready  (s_tready),
        .job_valid (front_valid),
        .job       (front_job),
        .job_ready (front_ready)
    );

    // Queue: decouple the byte side from output stalls
    bpu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_job    (front_job),
        .in_ready  (front_ready),
        .out_valid (back_valid),
        .out_job   (back_job),
        .out_ready (back_ready)
    );

    // Back: palette memory writes and reads, color expansion, output register
    bpu_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (back_valid),
        .job       (back_job),
        .job_ready (back_ready),
        .out_valid (m_tvalid),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue),
        .out_row   (pixel_row),
        .out_col   (pixel_col),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata = {2'b00, pixel_col, pixel_row, blue, green, red};

endmodule

FILE: hdl/bpu_ram.sv
module bpu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bpu_front.sv
module bpu_front #(
    parameter int MAX_WIDTH       = 2048,
    parameter int MAX_HEIGHT      = 2048,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  bpu_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          in_sof,
    output logic          in_ready,
    output logic          job_valid,
    output bpu_pkg::job_t job,
    input  logic          job_ready
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CCW = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PCW = $clog2(PALETTE_ENTRIES * 4);
    localparam logic [PCW-1:0] PAL_LAST = PCW'(PALETTE_ENTRIES * 4 - 1);

    logic           loading_reg, loading_next;
    logic [PCW-1:0] pal_cnt_reg, pal_cnt_next;
    logic [1:0]     bip_reg, bip_next;
    logic [23:0]    held_reg, held_next;
    logic [CCW-1:0] col_reg, col_next;
    logic [HW-1:0]  row_reg, row_next;
    logic [1:0]     pad_reg, pad_next;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [2:0]     bpp;
    logic [WW-1:0]  col_inc;
    logic           accept;

    // Clamp sizes into the supported range
    always_comb begin
        if (cfg.image_width == 12'd0) begin
            w_eff = WW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg.image_width);
        end
        if (cfg.image_height == 12'd0) begin
            h_eff = HW'(1);
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(cfg.image_height);
        end
    end

    assign bpp      = bpu_pkg::bytes_per_pixel(cfg.pixel_format);
    assign in_ready = job_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        loading_next = loading_reg;
        pal_cnt_next = pal_cnt_reg;
        bip_next     = bip_reg;
        held_next    = held_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pad_next     = pad_reg;
        col_inc      = WW'(col_reg) + WW'(1);
        job_valid    = 1'b0;
        job.kind     = bpu_pkg::JOB_PIXEL;
        job.fmt      = cfg.pixel_format;
        job.held     = held_reg;
        job.byte_val = in_byte;
        job.row      = 11'(h_eff - HW'(1) - row_reg);
        job.col      = 11'(col_reg);
        job.last     = 1'b0;

        if (in_sof) begin
            loading_next = (cfg.pixel_format == bpu_pkg::FMT_PAL);
            pal_cnt_next = '0;
            bip_next     = '0;
            held_next    = '0;
            col_next     = '0;
            row_next     = '0;
            pad_next     = '0;
            col_inc      = WW'(1);
            job.held     = '0;
            job.row      = 11'(h_eff - HW'(1));
            job.col      = '0;
        end

        if (loading_next) begin
            if (pal_cnt_next[1:0] == 2'd0) begin
                held_next = '0;
            end
            if (pal_cnt_next[1:0] != 2'd3) begin
                held_next = held_next | (24'(in_byte) << {pal_cnt_next[1:0], 3'b000});
            end else begin
                job_valid    = 1'b1;
                job.kind     = bpu_pkg::JOB_PAL_WRITE;
                job.held     = held_next;
                job.byte_val = 8'(pal_cnt_next[PCW-1:2]);
                held_next    = '0;
            end
            if (pal_cnt_next == PAL_LAST) begin
                loading_next = 1'b0;
            end
            pal_cnt_next = pal_cnt_next + PCW'(1);
        end else if (bpp != 3'd0 && row_next < h_eff) begin
            if (pad_next != 2'd0) begin
                // skip a padding byte, the row ends with the last one
                pad_next = pad_next - 2'd1;
                if (pad_next == 2'd0) begin
                    row_next = row_next + HW'(1);
                end
            end else if ({1'b0, bip_next} + 3'd1 < bpp) begin
                held_next = 24'(held_next | (24'(in_byte) << {bip_next, 3'b000}));
                bip_next  = bip_next + 2'd1;
            end else begin
                job_valid = 1'b1;
                job.last  = (row_next + HW'(1) >= h_eff) && (col_inc >= w_eff);
                bip_next  = '0;
                held_next = '0;
                if (col_inc >= w_eff) begin
                    col_next = '0;
                    pad_next = bpu_pkg::row_pad(w_eff[1:0], bpp);
                    if (pad_next == 2'd0) begin
                        row_next = row_next + HW'(1);
                    end
                end else begin
                    col_next = CCW'(col_inc);
                end
            end
        end

        job_valid = job_valid && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loading_reg <= 1'b0;
            pal_cnt_reg <= '0;
            bip_reg     <= '0;
            held_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
        end else if (accept) begin
            loading_reg <= loading_next;
            pal_cnt_reg <= pal_cnt_next;
            bip_reg     <= bip_next;
            held_reg    <= held_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
        end
    end

endmodule

FILE: hdl/bpu_queue.sv
module bpu_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  bpu_pkg::job_t in_job,
    output logic          in_ready,
    output logic          out_valid,
    output bpu_pkg::job_t out_job,
    input  logic          out_ready
);

    localparam int AW = bpu_pkg::QUEUE_AW;
    localparam int CW = AW + 1;

    bpu_pkg::job_t slot_reg [bpu_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(bpu_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(bpu_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CW'(bpu_pkg::QUEUE_DEPTH))
            |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

FILE: hdl/bpu_back.sv
module bpu_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    input  bpu_pkg::job_t job,
    output logic          job_ready,
    output logic          out_valid,
    output logic [7:0]    out_red,
    output logic [7:0]    out_green,
    output logic [7:0]    out_blue,
    output logic [10:0]   out_row,
    output logic [10:0]   out_col,
    output logic          out_last,
    input  logic          out_ready
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic          advance, pop;
    logic          ram_we;
    logic [23:0]   ram_rdata;

    logic          s1_valid_reg;
    bpu_pkg::job_t s1_job_reg;
    logic          s1_in_range_reg;

    logic          m_valid_reg;
    logic [7:0]    m_red_reg, m_green_reg, m_blue_reg;
    logic [10:0]   m_row_reg, m_col_reg;
    logic          m_last_reg;

    logic [7:0]    red_c, green_c, blue_c;
    logic [7:0]    lo, hi;
    logic [23:0]   entry;

    // The whole back moves when the output slot is free or being drained
    assign advance   = !m_valid_reg || out_ready;
    assign job_ready = advance;
    assign pop       = job_valid && advance;
    assign ram_we    = pop && (job.kind == bpu_pkg::JOB_PAL_WRITE);

    bpu_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (job.byte_val[AW-1:0]),
        .wdata (job.held),
        .re    (advance),
        .raddr (job.byte_val[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= pop && (job.kind == bpu_pkg::JOB_PIXEL);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_job_reg      <= job;
            s1_in_range_reg <= (32'(job.byte_val) < 32'(PALETTE_ENTRIES));
        end
    end

    // Expand the assembled bytes to 8-bit channels
    always_comb begin
        lo    = s1_job_reg.held[7:0];
        hi    = s1_job_reg.byte_val;
        entry = s1_in_range_reg ? ram_rdata : 24'd0;
        case (s1_job_reg.fmt)
            bpu_pkg::FMT_BGRX: begin
                blue_c  = s1_job_reg.held[7:0];
                green_c = s1_job_reg.held[15:8];
                red_c   = s1_job_reg.held[23:16];
            end
            bpu_pkg::FMT_BGR: begin
                blue_c  = s1_job_reg.held[7:0];
                green_c = s1_job_reg.held[15:8];
                red_c   = hi;
            end
            bpu_pkg::FMT_565: begin
                red_c   = {hi[7:3], 3'b000};
                green_c = {hi[2:0], lo[7:5], 2'b00};
                blue_c  = {lo[4:0], 3'b000};
            end
            bpu_pkg::FMT_555: begin
                red_c   = {hi[6:2], 3'b000};
                green_c = {hi[1:0], lo[7:5], 3'b000};
                blue_c  = {lo[4:0], 3'b000};
            end
            default: begin
                blue_c  = entry[7:0];
                green_c = entry[15:8];
                red_c   = entry[23:16];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_red_reg   <= red_c;
            m_green_reg <= green_c;
            m_blue_reg  <= blue_c;
            m_row_reg   <= s1_job_reg.row;
            m_col_reg   <= s1_job_reg.col;
            m_last_reg  <= s1_job_reg.last;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_red   = m_red_reg;
    assign out_green = m_green_reg;
    assign out_blue  = m_blue_reg;
    assign out_row   = m_row_reg;
    assign out_col   = m_col_reg;
    assign out_last  = m_last_reg;

    a_stall_holds_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("pixel in flight dropped during stall");

    a_s1_feeds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && advance) |=> m_valid_reg)
        else $error("pixel lost between palette read and output");

endmodule

FILE: verif/tb.sv
localparam int MAX_SIDE = 2048;
localparam int PAL_SIZE = 256;

typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] row;
    logic [10:0] col;
    logic        last;
} rgb_pixel_t;

// Tracks the unpacker's counters and palette byte by byte and keeps the pixels still owed.
class pixel_book;
    rgb_pixel_t  pixels_due[$];
    logic [23:0] palette[PAL_SIZE];
    bit          loading;
    int unsigned pal_bytes;
    int unsigned byte_pos;
    logic [31:0] held;
    int unsigned col;
    int unsigned row;
    int unsigned pad_left;
    logic [2:0]  fmt;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    int          mismatches;

    function new();
        foreach (palette[i]) palette[i] = '0;
        fmt        = bpu_pkg::FMT_BGR;
        width_reg  = 12'd1;
        height_reg = 12'd1;
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        loading   = 1'b0;
        pal_bytes = 0;
        byte_pos  = 0;
        held      = '0;
        col       = 0;
        row       = 0;
        pad_left  = 0;
    endfunction

    static function int unsigned fit(int unsigned v);
        if (v < 1) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    static function int unsigned bytes_of(logic [2:0] f);
        case (f) inside
            bpu_pkg::FMT_BGRX:                  return 4;
            bpu_pkg::FMT_BGR:                   return 3;
            bpu_pkg::FMT_565, bpu_pkg::FMT_555: return 2;
            bpu_pkg::FMT_PAL:                   return 1;
            default:                            return 0;
        endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] val);
        case (idx)
            bpu_pkg::CFG_FORMAT: fmt = val[2:0];
            bpu_pkg::CFG_WIDTH:  width_reg = val;
            bpu_pkg::CFG_HEIGHT: height_reg = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return pixels_due.size();
    endfunction

    function void take_byte(logic [7:0] d, bit sof);
        int unsigned w, h, bpp, slot, pad;
        rgb_pixel_t  px;
        logic [23:0] e;
        w   = fit(width_reg);
        h   = fit(height_reg);
        bpp = bytes_of(fmt);
        if (sof) begin
            restart();
            loading = (fmt == bpu_pkg::FMT_PAL);
        end
        if (loading) begin
            // B, G, R land in held; the reserved byte commits the entry
            slot = pal_bytes % 4;
            if (slot == 0) held = '0;
            if (slot < 3) begin
                held |= 32'(d) << (8 * slot);
            end else if (pal_bytes / 4 < PAL_SIZE) begin
                palette[pal_bytes / 4] = held[23:0];
                held = '0;
            end
            pal_bytes++;
            if (pal_bytes >= PAL_SIZE * 4) loading = 1'b0;
            return;
        end
        if (bpp == 0 || row >= h) return;
        if (pad_left > 0) begin
            pad_left--;
            if (pad_left == 0) row++;
            return;
        end
        if (byte_pos + 1 < bpp) begin
            held = (held | (32'(d) << (8 * (byte_pos % 4)))) & 32'h00FF_FFFF;
            byte_pos++;
            return;
        end
        case (fmt)
            bpu_pkg::FMT_BGRX: begin
                px.blue  = held[7:0];
                px.green = held[15:8];
                px.red   = held[23:16];
            end
            bpu_pkg::FMT_BGR: begin
                px.blue  = held[7:0];
                px.green = held[15:8];
                px.red   = d;
            end
            bpu_pkg::FMT_565: begin
                px.red   = {d[7:3], 3'b000};
                px.green = {d[2:0], held[7:5], 2'b00};
                px.blue  = {held[4:0], 3'b000};
            end
            bpu_pkg::FMT_555: begin
                px.red   = {d[6:2], 3'b000};
                px.green = {d[1:0], held[7:5], 3'b000};
                px.blue  = {held[4:0], 3'b000};
            end
            default: begin
                e        = palette[d];
                px.blue  = e[7:0];
                px.green = e[15:8];
                px.red   = e[23:16];
            end
        endcase
        px.row  = 11'(h - 1 - row);
        px.col  = 11'(col);
        px.last = (row + 1 >= h) && (col + 1 >= w);
        pixels_due.push_back(px);
        byte_pos = 0;
        held     = '0;
        col++;
        if (col >= w) begin
            col = 0;
            pad = (4 - ((w * bpp) % 4)) % 4;
            if (pad > 0) pad_left = pad;
            else row++;
        end
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endfunction

    function void match_pixel(logic [47:0] data, logic last);
        rgb_pixel_t want, got;
        got.red   = data[7:0];
        got.green = data[15:8];
        got.blue  = data[23:16];
        got.row   = data[34:24];
        got.col   = data[45:35];
        got.last  = last;
        if (pixels_due.size() == 0) begin
            flag($sformatf("unexpected pixel r=%02h g=%02h b=%02h row=%0d col=%0d last=%0b",
                           got.red, got.green, got.blue, got.row, got.col, got.last));
            return;
        end
        want = pixels_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
            flag($sformatf({"pixel mismatch: expected r=%02h g=%02h b=%02h row=%0d col=%0d ",
                            "last=%0b, got r=%02h g=%02h b=%02h row=%0d col=%0d last=%0b"},
                           want.red, want.green, want.blue, want.row, want.col, want.last,
                           got.red, got.green, got.blue, got.row, got.col, got.last));
        end
    endfunction
endclass

module tb;

    // Cycles to let palette writes and the output pipe settle after the last pixel
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [11:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [0:0]  s_tuser;    // [0] start_of_image
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // [7:0] red, [15:8] green, [23:16] blue, [34:24] row, [45:35] col
    logic        m_tlast;    // last_pixel

    pixel_book book;
    bit        steady = 1'b0;   // no gaps on either side while set
    int        rx_hold = 0;     // cycles the receiver still refuses pixels
    int        counted = 0;     // random-phase bytes that the block acts on

    bmp_pixel_unpacker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Upper bits of the format word are junk the block must drop
    function automatic logic [11:0] fmt_word(input logic [2:0] f);
        logic [8:0] junk;
        junk = $urandom_range(0, 1) ? 9'($urandom) : 9'd0;
        return {junk, f};
    endfunction

    function automatic logic [11:0] size_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 12'd0;
        if (r == 1) return 12'($urandom);
        return 12'($urandom_range(1, 8));
    endfunction

    // Offer one byte at the falling edge, hold it until taken, then log it
    task automatic send_byte(input logic [7:0] d, input bit sof);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tuser  = sof;
        do @(posedge aclk); while (s_tready !== 1'b1);
        book.take_byte(d, sof);
        @(negedge aclk);
    endtask

    // Stop offering, wait for every owed pixel, then let the back end go quiet
    task automatic drain();
        s_tvalid = 1'b0;
        while (book.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        book.write_reg(idx, val);
    endtask

    task automatic new_image(input logic [2:0] f, input logic [11:0] w, input logic [11:0] h);
        drain();
        set_reg(bpu_pkg::CFG_FORMAT, fmt_word(f));
        set_reg(bpu_pkg::CFG_WIDTH, w);
        set_reg(bpu_pkg::CFG_HEIGHT, h);
    endtask

    // Stream one whole image in the current format, palette first in 8-bit mode;
    // stop after cut bytes when cut is nonzero. Pad bytes carry random values.
    task automatic send_image(input int unsigned cut);
        int unsigned w, h, bpp, row_len, total;
        w       = book.fit(book.width_reg);
        h       = book.fit(book.height_reg);
        bpp     = book.bytes_of(book.fmt);
        row_len = w * bpp;
        row_len += (4 - row_len % 4) % 4;
        total   = h * row_len + ((book.fmt == bpu_pkg::FMT_PAL) ? PAL_SIZE * 4 : 0);
        if (bpp == 0) total = $urandom_range(1, 6);
        if (cut > 0 && cut < total) total = cut;
        for (int unsigned k = 0; k < total; k++) send_byte(8'($urandom), k == 0);
        if (bpp != 0) counted += total;
    endtask

    // Receiver: random stalls, plus a forced hold-off when rx_hold is loaded
    initial begin : rx_side
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    // Check every pixel taken at the rising edge against the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.match_pixel(m_tdata, m_tlast);
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [2:0] f;
        logic [1:0] reg_sel;
        int         kind;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = bpu_pkg::CFG_FORMAT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        book      = new();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: 24-bit, one pixel; drop the pad byte and the byte after the image
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);

        // 32-bit with zero sizes, which saturate to one
        new_image(bpu_pkg::FMT_BGRX, 12'd0, 12'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // 565: all ones, then all zeros
        new_image(bpu_pkg::FMT_565, 12'd2, 12'd1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);

        // 555 on an oversized height: bottom row reads 2047; skip the two pad bytes
        new_image(bpu_pkg::FMT_555, 12'd1, 12'hFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);

        // Undefined format: every byte dropped
        new_image(3'(bpu_pkg::FMT_PAL + 1), 12'd1, 12'd1);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);

        // Start of image in the middle of a pixel restarts the counters
        new_image(bpu_pkg::FMT_BGR, 12'd1, 12'd2);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        send_byte(8'h78, 0);
        send_byte(8'h9A, 0);

        // Full palette load followed by a small palette image
        new_image(bpu_pkg::FMT_PAL, 12'd3, 12'd2);
        send_image(0);

        // Palette load that finishes after the format turns undefined, then read it back
        new_image(bpu_pkg::FMT_PAL, 12'd2, 12'd1);
        send_image(300);
        drain();
        set_reg(bpu_pkg::CFG_FORMAT, fmt_word(3'(bpu_pkg::FMT_PAL + 2)));
        repeat (PAL_SIZE * 4 - 300 + 3) send_byte(8'($urandom), 1'b0);
        drain();
        set_reg(bpu_pkg::CFG_FORMAT, fmt_word(bpu_pkg::FMT_PAL));
        repeat (4) send_byte(8'($urandom), 1'b0);

        // Widest row: start in 24-bit, switch to palette mid-pixel so the held byte
        // completes at once, then walk all 2048 columns reading every palette entry
        new_image(bpu_pkg::FMT_BGR, 12'hFFF, 12'hFFF);
        send_byte(8'($urandom), 1'b1);
        drain();
        set_reg(bpu_pkg::CFG_FORMAT, fmt_word(bpu_pkg::FMT_PAL));
        for (int k = 0; k < MAX_SIDE + 3; k++) send_byte(8'(k), 1'b0);

        // Back-pressure: hold the receiver off while bytes keep coming
        steady = 1'b1;
        new_image(bpu_pkg::FMT_565, 12'd8, 12'd4);
        rx_hold = 300;
        send_image(0);
        steady = 1'b0;

        counted = 0;
        while (counted < 500) begin
            steady = ($urandom_range(0, 3) == 0);
            kind   = $urandom_range(0, 9);
            if (kind <= 5) begin
                // well-formed image, sometimes with bytes after its end
                f = 3'($urandom_range(0, 3));
                if ($urandom_range(0, 24) == 0) f = bpu_pkg::FMT_PAL;
                new_image(f, ($urandom_range(0, 9) == 0) ? 12'($urandom_range(8, 40))
                                                        : 12'($urandom_range(1, 7)),
                          12'($urandom_range(1, 3)));
                send_image(0);
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
                end
            end else if (kind == 6) begin
                // cut short, any sizes
                new_image(3'($urandom_range(0, 4)), size_word(), size_word());
                send_image($urandom_range(1, 12));
            end else if (kind <= 8) begin
                // registers change in the middle of an image
                new_image(3'($urandom_range(0, 3)), 12'($urandom_range(1, 6)),
                          12'($urandom_range(1, 3)));
                send_image($urandom_range(1, 10));
                drain();
                reg_sel = 2'($urandom_range(0, 2));
                case (reg_sel)
                    bpu_pkg::CFG_FORMAT:
                        set_reg(bpu_pkg::CFG_FORMAT, fmt_word(3'($urandom_range(0, 7))));
                    bpu_pkg::CFG_WIDTH:
                        set_reg(bpu_pkg::CFG_WIDTH, size_word());
                    default:
                        set_reg(bpu_pkg::CFG_HEIGHT, size_word());
                endcase
                repeat ($urandom_range(4, 30)) begin
                    send_byte(8'($urandom), $urandom_range(0, 15) == 0);
                    counted++;
                end
            end else begin
                // undefined format
                new_image(3'($urandom_range(5, 7)), size_word(), size_word());
                send_image(0);
            end
        end
        steady = 1'b0;

        drain();
        if (book.mismatches == 0 && book.pending() == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule
